/* sv/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define MES_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define MES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* sv/mes_pkg.sv */
// types, codes and constants of the markov event sequencer
`timescale 1ns / 1ps
`default_nettype none
package mes_pkg;

  localparam int unsigned MAX_EVENTS_DEF = 16;
  localparam int unsigned DRAW_W         = 15;
  localparam int unsigned WEIGHT_W       = 16;
  localparam int unsigned LEVEL_W        = 32;
  localparam int unsigned PERIOD_W       = 24;
  localparam int unsigned ACTIVE_W       = 5;
  localparam int unsigned CFG_IDX_W      = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd44100;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd4;

  // operation codes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_TRIGGER = 2'd1;
  localparam logic [1:0] OP_WEIGHT  = 2'd2;
  localparam logic [1:0] OP_VALUE   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_PERIOD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_EVENTS = 2'd2;

  typedef struct packed {
    logic                       manual_mode;
    logic [PERIOD_W-1:0]        event_period;
    logic [ACTIVE_W-1:0]        active_events;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                 operation;
    logic [DRAW_W-1:0]          random_draw;
    logic [3:0]                 row_index;
    logic [3:0]                 column_index;
    logic signed [LEVEL_W-1:0]  data_word;
  } in_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0]  level;
    logic [3:0]                 state_now;
    logic [PERIOD_W-1:0]        position;
    logic                       moved;
  } out_t;

endpackage
`default_nettype wire

/* sv/mes_ram.sv */
// generic single-port synchronous ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module mes_ram #(
  parameter int unsigned WIDTH = mes_pkg::WEIGHT_W,
  parameter int unsigned DEPTH = mes_pkg::MAX_EVENTS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule
`default_nettype wire

/* sv/mes_cfg.sv */
// configuration register file
`timescale 1ns / 1ps
`default_nettype none
module mes_cfg (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [mes_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [mes_pkg::PERIOD_W-1:0]       cfg_data_i,
  output mes_pkg::cfg_t                           cfg_o
);

  mes_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mes_pkg::CFG_MANUAL_MODE:   cfg_d.manual_mode   = cfg_data_i[0];
        mes_pkg::CFG_EVENT_PERIOD:  cfg_d.event_period  = cfg_data_i;
        mes_pkg::CFG_ACTIVE_EVENTS: cfg_d.active_events = cfg_data_i[mes_pkg::ACTIVE_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.manual_mode   <= 1'b0;
      cfg_q.event_period  <= mes_pkg::PERIOD_RESET;
      cfg_q.active_events <= mes_pkg::ACTIVE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

/* sv/mes_ctrl.sv */
// sequencer: clearing pass, table updates, tick handling and transition walk
`timescale 1ns / 1ps
`default_nettype none
module mes_ctrl #(
  parameter int unsigned MAX_EVENTS = mes_pkg::MAX_EVENTS_DEF,
  parameter int unsigned EW         = $clog2(MAX_EVENTS),
  parameter int unsigned SW         = mes_pkg::WEIGHT_W + EW,
  parameter int unsigned RW         = mes_pkg::LEVEL_W + SW
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mes_pkg::cfg_t                 cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire mes_pkg::in_t                  in_data_i,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output mes_pkg::out_t                      res_o,
  // weight memory
  output logic                               w_en_o,
  output logic                               w_we_o,
  output logic [2*EW-1:0]                    w_addr_o,
  output logic [mes_pkg::WEIGHT_W-1:0]       w_wdata_o,
  input  wire logic [mes_pkg::WEIGHT_W-1:0]  w_rdata_i,
  // row memory: value above, row sum below
  output logic                               r_en_o,
  output logic                               r_we_o,
  output logic [EW-1:0]                      r_addr_o,
  output logic [RW-1:0]                      r_wdata_o,
  input  wire logic [RW-1:0]                 r_rdata_i
);

  localparam int unsigned WAW = 2 * EW;
  localparam int unsigned CW  = $clog2(MAX_EVENTS + 1);
  localparam int unsigned PW  = mes_pkg::DRAW_W + SW;
  localparam int unsigned PRW = mes_pkg::PERIOD_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WB    = 4'd2;
  localparam logic [3:0] S_TICK  = 4'd3;
  localparam logic [3:0] S_SCALE = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;
  localparam logic [3:0] S_LEVEL = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [3:0]                  state_q, state_d;
  logic [WAW-1:0]              clr_q, clr_d;
  mes_pkg::in_t                item_q, item_d;
  logic                        pending_q, pending_d;
  logic [PRW-1:0]              count_q, count_d;
  logic [EW-1:0]               cur_q, cur_d;
  logic [mes_pkg::LEVEL_W-1:0] level_q, level_d;
  logic [SW-1:0]               rem_q, rem_d;
  logic [CW-1:0]               col_q, col_d;
  logic [EW-1:0]               pick_q, pick_d;
  logic                        moved_q, moved_d;

  logic [CW-1:0]  walk_len;
  logic [CW-1:0]  col_nx;
  logic [EW-1:0]  clr_row;
  logic [SW-1:0]  row_sum;
  logic [SW-1:0]  wt_ext;
  logic [PW-1:0]  prod;
  logic [PRW:0]   cnt_nx;
  logic           fire;
  logic           in_row_ok;
  logic           in_col_ok;

  always_comb begin
    if (32'(cfg_i.active_events) > MAX_EVENTS) begin
      walk_len = CW'(MAX_EVENTS);
    end else begin
      walk_len = CW'(cfg_i.active_events);
    end
  end

  assign col_nx    = col_q + CW'(1);
  assign clr_row   = clr_q[WAW-1 -: EW];
  assign row_sum   = r_rdata_i[SW-1:0];
  assign wt_ext    = SW'(w_rdata_i);
  assign prod      = PW'(item_q.random_draw) * PW'(row_sum);
  assign cnt_nx    = {1'b0, count_q} + (PRW+1)'(1);
  assign in_row_ok = 32'(in_data_i.row_index) < MAX_EVENTS;
  assign in_col_ok = 32'(in_data_i.column_index) < MAX_EVENTS;

  always_comb begin
    if (cfg_i.manual_mode) begin
      fire = pending_q;
    end else begin
      fire = cnt_nx >= {1'b0, cfg_i.event_period};
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    item_d    = item_q;
    pending_d = pending_q;
    count_d   = count_q;
    cur_d     = cur_q;
    level_d   = level_q;
    rem_d     = rem_q;
    col_d     = col_q;
    pick_d    = pick_q;
    moved_d   = moved_q;

    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    w_en_o      = 1'b0;
    w_we_o      = 1'b0;
    w_addr_o    = {cur_q, col_q[EW-1:0]};
    w_wdata_o   = '0;
    r_en_o      = 1'b0;
    r_we_o      = 1'b0;
    r_addr_o    = cur_q;
    r_wdata_o   = '0;

    unique case (state_q)
      S_CLEAR: begin
        w_en_o   = 1'b1;
        w_we_o   = 1'b1;
        w_addr_o = clr_q;
        r_en_o   = 32'(clr_row) < MAX_EVENTS;
        r_we_o   = 1'b1;
        r_addr_o = clr_row;
        clr_d    = clr_q + WAW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d = in_data_i;
          unique case (in_data_i.operation)
            mes_pkg::OP_TICK: begin
              state_d = S_TICK;
            end
            mes_pkg::OP_TRIGGER: begin
              pending_d = 1'b1;
            end
            mes_pkg::OP_WEIGHT: begin
              if (in_row_ok && in_col_ok) begin
                w_en_o   = 1'b1;
                w_addr_o = {EW'(in_data_i.row_index), EW'(in_data_i.column_index)};
                r_en_o   = 1'b1;
                r_addr_o = EW'(in_data_i.row_index);
                state_d  = S_WB;
              end
            end
            mes_pkg::OP_VALUE: begin
              if (in_row_ok) begin
                r_en_o   = 1'b1;
                r_addr_o = EW'(in_data_i.row_index);
                state_d  = S_WB;
              end
            end
            default: ;
          endcase
        end
      end

      S_WB: begin
        // write back the modified row entry, and the weight for a weight write
        r_en_o   = 1'b1;
        r_we_o   = 1'b1;
        r_addr_o = EW'(item_q.row_index);
        if (item_q.operation == mes_pkg::OP_WEIGHT) begin
          w_en_o    = 1'b1;
          w_we_o    = 1'b1;
          w_addr_o  = {EW'(item_q.row_index), EW'(item_q.column_index)};
          w_wdata_o = item_q.data_word[mes_pkg::WEIGHT_W-1:0];
          r_wdata_o = {r_rdata_i[RW-1:SW],
                       row_sum - wt_ext + SW'(item_q.data_word[mes_pkg::WEIGHT_W-1:0])};
        end else begin
          r_wdata_o = {item_q.data_word, row_sum};
        end
        state_d = S_IDLE;
      end

      S_TICK: begin
        moved_d = fire;
        if (cfg_i.manual_mode) begin
          if (fire) begin
            pending_d = 1'b0;
          end
        end else begin
          count_d = fire ? '0 : cnt_nx[PRW-1:0];
        end
        if (fire) begin
          r_en_o  = 1'b1;
          r_addr_o = cur_q;
          state_d = S_SCALE;
        end else begin
          state_d = S_OUT;
        end
      end

      S_SCALE: begin
        rem_d = prod[mes_pkg::DRAW_W +: SW];
        col_d = '0;
        if (walk_len == '0) begin
          pick_d   = '0;
          r_en_o   = 1'b1;
          r_addr_o = '0;
          state_d  = S_LEVEL;
        end else begin
          w_en_o   = 1'b1;
          w_addr_o = {cur_q, EW'(0)};
          state_d  = S_WALK;
        end
      end

      S_WALK: begin
        if (rem_q < wt_ext) begin
          pick_d   = col_q[EW-1:0];
          r_en_o   = 1'b1;
          r_addr_o = col_q[EW-1:0];
          state_d  = S_LEVEL;
        end else begin
          rem_d = rem_q - wt_ext;
          if (col_nx == walk_len) begin
            pick_d   = '0;
            r_en_o   = 1'b1;
            r_addr_o = '0;
            state_d  = S_LEVEL;
          end else begin
            col_d    = col_nx;
            w_en_o   = 1'b1;
            w_addr_o = {cur_q, col_nx[EW-1:0]};
          end
        end
      end

      S_LEVEL: begin
        cur_d   = pick_q;
        level_d = r_rdata_i[RW-1:SW];
        state_d = S_OUT;
      end

      S_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.level     = level_q;
  assign res_o.state_now = 4'(cur_q);
  assign res_o.position  = count_q;
  assign res_o.moved     = moved_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      pending_q <= 1'b0;
      count_q   <= '0;
      cur_q     <= '0;
      level_q   <= '0;
      moved_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      pending_q <= pending_d;
      count_q   <= count_d;
      cur_q     <= cur_d;
      level_q   <= level_d;
      moved_q   <= moved_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    rem_q  <= rem_d;
    col_q  <= col_d;
    pick_q <= pick_d;
  end

endmodule
`default_nettype wire

/* sv/markov_event_sequencer.sv */
// top level of the markov event sequencer
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------
//  in      | to block  | in_valid_i / in_ready_o   | in_data_i  (mes_pkg::in_t)
//  out     | from block| out_valid_o / out_ready_i | out_data_o (mes_pkg::out_t)
//  cfg     | to block  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  a trigger is taken in idle; a weight or value write reads, then writes back
//  a tick with no transition goes to output; with a transition it scales
//  the draw and walks up to MAX_EVENTS columns, one weight-memory read per column
//  after reset a clearing pass over 2**(2*clog2(MAX_EVENTS)) weight entries
//  zeroes both memories, with in_ready_o low; cfg transfers are taken throughout
//  the output register lets a new item in while a result waits for out_ready_i
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module markov_event_sequencer #(
  parameter int unsigned MAX_EVENTS = mes_pkg::MAX_EVENTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire mes_pkg::in_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output mes_pkg::out_t                      out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [mes_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mes_pkg::PERIOD_W-1:0]  cfg_data_i
);

  localparam int unsigned EW     = $clog2(MAX_EVENTS);
  localparam int unsigned SW     = mes_pkg::WEIGHT_W + EW;
  localparam int unsigned RW     = mes_pkg::LEVEL_W + SW;
  localparam int unsigned WDEPTH = 1 << (2 * EW);

  mes_pkg::cfg_t cfg;
  mes_pkg::out_t res;
  logic          res_valid;
  logic          res_ready;

  // weight memory port
  logic                        w_en, w_we;
  logic [2*EW-1:0]             w_addr;
  logic [mes_pkg::WEIGHT_W-1:0] w_wdata, w_rdata;

  // row memory port: value and running row sum side by side
  logic          r_en, r_we;
  logic [EW-1:0] r_addr;
  logic [RW-1:0] r_wdata, r_rdata;

  // output register
  logic          out_valid_q, out_valid_d;
  mes_pkg::out_t out_q;

  mes_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mes_ctrl #(
    .MAX_EVENTS (MAX_EVENTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .w_en_o      (w_en),
    .w_we_o      (w_we),
    .w_addr_o    (w_addr),
    .w_wdata_o   (w_wdata),
    .w_rdata_i   (w_rdata),
    .r_en_o      (r_en),
    .r_we_o      (r_we),
    .r_addr_o    (r_addr),
    .r_wdata_o   (r_wdata),
    .r_rdata_i   (r_rdata)
  );

  // one weight per entry, row-major by source state
  mes_ram #(
    .WIDTH (mes_pkg::WEIGHT_W),
    .DEPTH (WDEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .en_i    (w_en),
    .we_i    (w_we),
    .addr_i  (w_addr),
    .wdata_i (w_wdata),
    .rdata_o (w_rdata)
  );

  // one entry per state: level value and sum of its row of weights
  mes_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_EVENTS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .en_i    (r_en),
    .we_i    (r_we),
    .addr_i  (r_addr),
    .wdata_i (r_wdata),
    .rdata_o (r_rdata)
  );

  // the register takes a new result when empty or draining this cycle
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a result refused by a full output register is offered again unchanged
  `MES_ASSERT_NEXT(a_res_held, clk_i, rst_ni, res_valid && !res_ready, res_valid && $stable(res))

  // no new item is taken while the sequencer offers a result
  `MES_ASSERT_NOW(a_no_accept_on_res, clk_i, rst_ni, res_valid, !in_ready_o)

  // an accepted item never yields a result in the very next cycle
  `MES_ASSERT_NEXT(a_no_instant_res, clk_i, rst_ni, in_valid_i && in_ready_o, !res_valid)

  // in clocked mode a transition always restarts the sample count
  `MES_ASSERT_NOW(a_moved_restarts, clk_i, rst_ni,
    out_valid_o && out_data_o.moved && !cfg.manual_mode, out_data_o.position == '0)

endmodule
`default_nettype wire
